FILE: hdl/rma_pkg.sv
// shared types and constants for the resource map allocator
`default_nettype none
package rma_pkg;

    localparam int FIELD_W = 24;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ALLOC,
        CMD_TAKE,
        CMD_MERGE_LO,
        CMD_MERGE_HI,
        CMD_MERGE_BOTH,
        CMD_INSERT
    } t_cmd;

    typedef struct packed {
        logic capture;
        t_cmd cmd;
    } t_cell_ctl;

    typedef struct packed {
        logic sel;
        logic exact;
        logic lower_hit;
        logic upper_hit;
    } t_cell_rpt;

endpackage
`default_nettype wire

FILE: hdl/rma_if.sv
// request and response channel interfaces of the allocator
`default_nettype none
interface rma_req_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [rma_pkg::FIELD_W-1:0] unit_count;
    logic [rma_pkg::FIELD_W-1:0] base_address;
    modport source (output valid, action, unit_count, base_address, input ready);
    modport sink (input valid, action, unit_count, base_address, output ready);
endinterface

interface rma_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [rma_pkg::FIELD_W-1:0] granted_base;
    logic [1:0]                 status;
    modport source (output valid, granted_base, status, input ready);
    modport sink (input valid, granted_base, status, output ready);
endinterface
`default_nettype wire

FILE: hdl/rma_cell.sv
// one extent row of the free map, with compare flags and shift moves
`default_nettype none
module rma_cell #(
    parameter int W = 24
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rma_pkg::t_cell_ctl  i_ctl,
    input  wire [W-1:0]         i_sz,
    input  wire [W-1:0]         i_ad,
    input  wire [W-1:0]         i_top,
    input  wire                 i_left_valid,
    input  wire [W-1:0]         i_left_base,
    input  wire [W-1:0]         i_left_len,
    input  wire                 i_left_le,
    input  wire                 i_right_valid,
    input  wire [W-1:0]         i_right_base,
    input  wire [W-1:0]         i_right_len,
    input  wire                 i_right_le,
    input  wire                 i_pf,
    output logic                o_pf,
    output logic                o_valid,
    output logic [W-1:0]        o_base,
    output logic [W-1:0]        o_len,
    output logic                o_le,
    output rma_pkg::t_cell_rpt  o_rpt,
    output logic [W-1:0]        o_grant
);

    logic         r_valid, n_valid;
    logic [W-1:0] r_base, n_base;
    logic [W-1:0] r_len, n_len;
    logic         r_fit, r_le, r_end, r_top;
    logic         sel, lowc, insc;

    assign sel  = r_fit & ~i_pf;
    assign lowc = r_le & ~i_right_le;
    assign insc = ~r_le & i_left_le;

    assign o_pf    = i_pf | r_fit;
    assign o_valid = r_valid;
    assign o_base  = r_base;
    assign o_len   = r_len;
    assign o_le    = r_le;
    assign o_grant = sel ? r_base : '0;
    assign o_rpt   = '{sel: sel, exact: sel & (r_len == i_sz), lower_hit: lowc & r_end,
                       upper_hit: insc & r_top};

    always_comb begin
        n_valid = r_valid;
        n_base  = r_base;
        n_len   = r_len;
        case (i_ctl.cmd)
            rma_pkg::CMD_ALLOC: begin
                if (sel) begin
                    n_base = r_base + i_sz;
                    n_len  = r_len - i_sz;
                end
            end
            rma_pkg::CMD_TAKE: begin
                if (sel || i_pf) begin
                    n_valid = i_right_valid;
                    n_base  = i_right_base;
                    n_len   = i_right_len;
                end
            end
            rma_pkg::CMD_MERGE_BOTH: begin
                if (lowc) begin
                    n_len = r_len + i_sz + i_right_len;
                end else if (!r_le) begin
                    n_valid = i_right_valid;
                    n_base  = i_right_base;
                    n_len   = i_right_len;
                end
            end
            rma_pkg::CMD_MERGE_LO: begin
                if (lowc) begin
                    n_len = r_len + i_sz;
                end
            end
            rma_pkg::CMD_MERGE_HI: begin
                if (insc) begin
                    n_base = i_ad;
                    n_len  = r_len + i_sz;
                end
            end
            rma_pkg::CMD_INSERT: begin
                if (insc) begin
                    n_valid = 1'b1;
                    n_base  = i_ad;
                    n_len   = i_sz;
                end else if (!r_le) begin
                    n_valid = i_left_valid;
                    n_base  = i_left_base;
                    n_len   = i_left_len;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_base <= n_base;
        r_len  <= n_len;
        if (i_ctl.capture) begin
            r_fit <= r_valid & (r_len >= i_sz);
            r_le  <= r_valid & (r_base <= i_ad);
            r_end <= r_valid & (({1'b0, r_base} + {1'b0, r_len}) == {1'b0, i_ad});
            r_top <= r_valid & (r_base == i_top);
        end
    end

endmodule
`default_nettype wire

FILE: hdl/resource_map_allocator_core.sv
// top level: request sequencer and the row of extent cells
// A first-fit free-space map of MAP_ENTRIES extents held in a row of cells, sorted by base. A
// request goes from acceptance through S_CMP (compare in all cells), S_DEC (decide) and S_UPD
// (one shift/update of the row) to a ready response; an illegal request, or a free of zero units,
// answers from S_IDLE without these states. One request is in flight at a time, and the next is
// taken once the response has been taken. The map is empty after reset, with no clearing pass.
`default_nettype none
module resource_map_allocator_core #(
    parameter int MAP_ENTRIES = 64,
    parameter int UNIT_BITS   = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rma_req_if.sink     i_req,
    rma_rsp_if.source   o_rsp
);

    localparam int XW = ((UNIT_BITS > rma_pkg::FIELD_W) ? UNIT_BITS : rma_pkg::FIELD_W) + 1;
    localparam int N  = MAP_ENTRIES;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_DEC, S_UPD} t_state;

    t_state                     r_state;
    logic                       r_out_valid;
    rma_pkg::t_status           r_status;
    logic [rma_pkg::FIELD_W-1:0] r_grant;
    logic                       r_action;
    logic [UNIT_BITS-1:0]       r_sz, r_ad, r_top;
    rma_pkg::t_cmd              r_cmd;

    logic [XW-1:0] x_sz, x_ad, x_top, x_mask;
    logic          illegal, nop_free, accept;

    logic                 c_valid [N];
    logic [UNIT_BITS-1:0] c_base  [N];
    logic [UNIT_BITS-1:0] c_len   [N];
    logic                 c_le    [N];
    logic [N:0]           c_pf;
    rma_pkg::t_cell_rpt   c_rpt   [N];
    logic [UNIT_BITS-1:0] c_grant [N];
    rma_pkg::t_cell_ctl   ctl;

    logic                 any_fit, any_take, any_lo, any_hi;
    logic [UNIT_BITS-1:0] grant_or;

    assign x_mask  = {{(XW-UNIT_BITS){1'b0}}, {UNIT_BITS{1'b1}}};
    assign x_sz    = XW'(i_req.unit_count);
    assign x_ad    = XW'(i_req.base_address);
    assign x_top   = x_sz + x_ad;
    assign illegal = i_req.action ? ((x_sz > x_mask) || (x_ad > x_mask) || (x_top > x_mask))
                                  : ((x_sz == '0) || (x_sz > x_mask));
    assign nop_free = i_req.action && (x_sz == '0);

    assign i_req.ready        = (r_state == S_IDLE) && !r_out_valid;
    assign accept             = i_req.valid && i_req.ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.granted_base = r_grant;

    assign ctl.capture = (r_state == S_CMP);
    assign ctl.cmd     = (r_state == S_UPD) ? r_cmd : rma_pkg::CMD_NONE;

    assign c_pf[0] = 1'b0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        rma_cell #(.W(UNIT_BITS)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_sz          (r_sz),
            .i_ad          (r_ad),
            .i_top         (r_top),
            .i_left_valid  ((g == 0) ? 1'b0 : c_valid[(g == 0) ? 0 : g-1]),
            .i_left_base   (c_base[(g == 0) ? 0 : g-1]),
            .i_left_len    (c_len[(g == 0) ? 0 : g-1]),
            .i_left_le     ((g == 0) ? 1'b1 : c_le[(g == 0) ? 0 : g-1]),
            .i_right_valid ((g == N-1) ? 1'b0 : c_valid[(g == N-1) ? g : g+1]),
            .i_right_base  (c_base[(g == N-1) ? g : g+1]),
            .i_right_len   (c_len[(g == N-1) ? g : g+1]),
            .i_right_le    ((g == N-1) ? 1'b0 : c_le[(g == N-1) ? g : g+1]),
            .i_pf          (c_pf[g]),
            .o_pf          (c_pf[g+1]),
            .o_valid       (c_valid[g]),
            .o_base        (c_base[g]),
            .o_len         (c_len[g]),
            .o_le          (c_le[g]),
            .o_rpt         (c_rpt[g]),
            .o_grant       (c_grant[g])
        );
    end

    always_comb begin
        any_fit  = c_pf[N];
        any_take = 1'b0;
        any_lo   = 1'b0;
        any_hi   = 1'b0;
        grant_or = '0;
        for (int k = 0; k < N; k++) begin
            any_take = any_take | c_rpt[k].exact;
            any_lo   = any_lo | c_rpt[k].lower_hit;
            any_hi   = any_hi | c_rpt[k].upper_hit;
            grant_or = grant_or | c_grant[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cmd       <= rma_pkg::CMD_NONE;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_action <= i_req.action;
                        r_sz     <= UNIT_BITS'(x_sz);
                        r_ad     <= UNIT_BITS'(x_ad);
                        r_top    <= UNIT_BITS'(x_top);
                        r_grant  <= '0;
                        if (illegal) begin
                            r_status    <= rma_pkg::ST_ILLEGAL;
                            r_out_valid <= 1'b1;
                        end else if (nop_free) begin
                            r_status    <= rma_pkg::ST_OK;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state  <= S_UPD;
                    r_status <= rma_pkg::ST_OK;
                    if (!r_action) begin
                        if (any_fit) begin
                            r_cmd   <= any_take ? rma_pkg::CMD_TAKE : rma_pkg::CMD_ALLOC;
                            r_grant <= rma_pkg::FIELD_W'(grant_or);
                        end else begin
                            r_cmd    <= rma_pkg::CMD_NONE;
                            r_status <= rma_pkg::ST_NOSPACE;
                        end
                    end else if (any_lo && any_hi) begin
                        r_cmd <= rma_pkg::CMD_MERGE_BOTH;
                    end else if (any_lo) begin
                        r_cmd <= rma_pkg::CMD_MERGE_LO;
                    end else if (any_hi) begin
                        r_cmd <= rma_pkg::CMD_MERGE_HI;
                    end else if (c_valid[N-1]) begin
                        r_cmd    <= rma_pkg::CMD_NONE;
                        r_status <= rma_pkg::ST_FULL;
                    end else begin
                        r_cmd <= rma_pkg::CMD_INSERT;
                    end
                end
                S_UPD: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    r_cmd       <= rma_pkg::CMD_NONE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rma_checker.sv
// port-level checks for the allocator and their bind
`default_nettype none
module rma_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_req_valid,
    input wire        i_req_ready,
    input wire        i_req_action,
    input wire [23:0] i_req_unit_count,
    input wire        i_rsp_valid,
    input wire        i_rsp_ready,
    input wire [23:0] i_rsp_granted_base,
    input wire [1:0]  i_rsp_status
);

    logic r_busy;
    logic r_zero_alloc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_zero_alloc <= 1'b0;
        end else if (i_req_valid && i_req_ready) begin
            r_busy       <= 1'b1;
            r_zero_alloc <= !i_req_action && (i_req_unit_count == '0);
        end else if (i_rsp_valid && i_rsp_ready) begin
            r_busy <= 1'b0;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_granted_base))
        else $error("response dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |-> !r_busy)
        else $error("request taken while another is outstanding");

    a_rsp_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_busy)
        else $error("response without a request");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_granted_base != '0) |-> (i_rsp_status == rma_pkg::ST_OK))
        else $error("nonzero base on a failed request");

    a_zero_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && r_zero_alloc |-> (i_rsp_status == rma_pkg::ST_ILLEGAL))
        else $error("zero-size allocate not flagged");

endmodule

bind resource_map_allocator_core rma_checker u_rma_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_req_action       (i_req.action),
    .i_req_unit_count   (i_req.unit_count),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_granted_base (o_rsp.granted_base),
    .i_rsp_status       (o_rsp.status)
);
`default_nettype wire
